>>> src/page_line_pointer_checker_core_defines.svh
// Assertion macros for the slot directory checker.
// Included by the top level; no dependencies.
`ifndef PAGE_LINE_POINTER_CHECKER_CORE_DEFINES_SVH
`define PAGE_LINE_POINTER_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define PLPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset.
`define PLPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLPC_ASSERT(lbl, clk, rstn, prop, msg)
`define PLPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/plpc_pkg.sv
// Shared types, codes and constants of the slot directory checker.
// No dependencies; imported by the sequencer, the top level and the testbench.
package plpc_pkg;

  localparam int unsigned MAX_SLOTS    = 512;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned SLOT_AW      = $clog2(MAX_SLOTS);
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned POS_W        = 15;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SLOTS);

  localparam logic [POS_W-1:0] LOWER_RST   = POS_W'(24);
  localparam logic [POS_W-1:0] UPPER_RST   = POS_W'(8192);
  localparam logic [POS_W-1:0] SPECIAL_RST = POS_W'(8192);

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL = CFG_IDX_W'(2);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FL_UNUSED   = 2'd0,
    FL_NORMAL   = 2'd1,
    FL_REDIRECT = 2'd2,
    FL_DEAD     = 2'd3
  } flags_e;

  typedef enum logic [2:0] {
    V_OK          = 3'd0,
    V_REDIR_LEN   = 3'd1,
    V_REDIR_RANGE = 3'd2,
    V_REDIR_FLAGS = 3'd3,
    V_UNUSED_LEN  = 3'd4,
    V_BELOW_UPPER = 3'd5,
    V_PAST_SPEC   = 3'd6,
    V_OVERLAP     = 3'd7
  } verdict_e;

  // One slot table word: flags, offset, length.
  typedef struct packed {
    flags_e           flags;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] len;
  } plpc_entry_t;

  typedef struct packed {
    logic [POS_W-1:0] lower;
    logic [POS_W-1:0] upper;
    logic [POS_W-1:0] special;
  } plpc_bounds_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    verdict_e         verdict;
    logic [IDX_W-1:0] ovl;
  } plpc_result_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } plpc_stat_t;

endpackage

>>> src/plpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module plpc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/plpc_seq.sv
// Check sequencer: reads the checked entry, a redirect target or the earlier
// entries from the slot table and forms the verdict. Depends on plpc_pkg.
module plpc_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [plpc_pkg::IDX_W-1:0]     start_idx_i,
  input  plpc_pkg::plpc_bounds_t         bounds_i,
  input  plpc_pkg::plpc_entry_t          rdata_i,
  output logic [plpc_pkg::SLOT_AW-1:0]   raddr_o,
  input  logic                           res_ack_i,
  output plpc_pkg::plpc_stat_t           stat_o,
  output plpc_pkg::plpc_result_t         res_o
);
  import plpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ENTRY  = 5'b00010,
    S_TARGET = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  localparam logic [POS_W-1:0] HDR     = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] MAX_TGT = POS_W'(MAX_SLOTS);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [POS_W-1:0] a_off_q, a_off_d;
  logic [POS_W:0]   a_end_q, a_end_d;
  verdict_e         verdict_q, verdict_d;
  logic [IDX_W-1:0] ovl_q, ovl_d;

  logic [POS_W-1:0] lo_diff, max_tgt, tgt_m1;
  logic [POS_W:0]   ent_end;
  logic [IDX_W-1:0] idx_m1;
  logic             b_store, b_hit;

  assign lo_diff = bounds_i.lower - HDR;
  assign max_tgt = (bounds_i.lower >= HDR) ? {2'b00, lo_diff[POS_W-1:2]} : '0;
  assign tgt_m1  = rdata_i.off - POS_W'(1);
  assign ent_end = {1'b0, rdata_i.off} + {1'b0, rdata_i.len};
  assign idx_m1  = start_idx_i - IDX_W'(1);

  // An earlier entry takes storage when normal, or dead with a length.
  assign b_store = (rdata_i.flags == FL_NORMAL) ||
                   ((rdata_i.flags == FL_DEAD) && (rdata_i.len != '0));
  assign b_hit   = b_store && !((a_end_q <= {1'b0, rdata_i.off}) ||
                                (ent_end <= {1'b0, a_off_q}));

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    k_d       = k_q;
    a_off_d   = a_off_q;
    a_end_d   = a_end_q;
    verdict_d = verdict_q;
    ovl_d     = ovl_q;
    raddr_o   = '0;
    case (state_q)
      S_IDLE: begin
        raddr_o = idx_m1[SLOT_AW-1:0];
        if (start_i) begin
          idx_d   = start_idx_i;
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        a_off_d   = rdata_i.off;
        a_end_d   = ent_end;
        ovl_d     = '0;
        k_d       = IDX_W'(1);
        verdict_d = V_OK;
        state_d   = S_DONE;
        case (rdata_i.flags)
          FL_REDIRECT: begin
            if (rdata_i.len != '0) begin
              verdict_d = V_REDIR_LEN;
            end else if ((rdata_i.off == '0) || (rdata_i.off > max_tgt) ||
                         (rdata_i.off > MAX_TGT)) begin
              verdict_d = V_REDIR_RANGE;
            end else begin
              raddr_o = tgt_m1[SLOT_AW-1:0];
              state_d = S_TARGET;
            end
          end
          FL_UNUSED: begin
            if (rdata_i.len != '0) begin
              verdict_d = V_UNUSED_LEN;
            end
          end
          FL_NORMAL, FL_DEAD: begin
            if ((rdata_i.flags == FL_DEAD) && (rdata_i.len == '0)) begin
              verdict_d = V_OK;
            end else if (rdata_i.off < bounds_i.upper) begin
              verdict_d = V_BELOW_UPPER;
            end else if (ent_end > {1'b0, bounds_i.special}) begin
              verdict_d = V_PAST_SPEC;
            end else if (idx_q != IDX_W'(1)) begin
              raddr_o = '0;
              state_d = S_SCAN;
            end
          end
          default: begin
            verdict_d = V_OK;
          end
        endcase
      end
      S_TARGET: begin
        verdict_d = ((rdata_i.flags == FL_NORMAL) || (rdata_i.flags == FL_DEAD)) ?
                    V_OK : V_REDIR_FLAGS;
        state_d   = S_DONE;
      end
      S_SCAN: begin
        // The read data belongs to slot k_q; the next slot is requested now.
        if (b_hit) begin
          verdict_d = V_OVERLAP;
          ovl_d     = k_q;
          state_d   = S_DONE;
        end else if (k_q == idx_q - IDX_W'(1)) begin
          state_d = S_DONE;
        end else begin
          raddr_o = k_q[SLOT_AW-1:0];
          k_d     = k_q + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    k_q       <= k_d;
    a_off_q   <= a_off_d;
    a_end_q   <= a_end_d;
    verdict_q <= verdict_d;
    ovl_q     <= ovl_d;
  end

  assign stat_o.idle      = (state_q == S_IDLE);
  assign stat_o.res_valid = (state_q == S_DONE);
  assign res_o.idx        = idx_q;
  assign res_o.verdict    = verdict_q;
  assign res_o.ovl        = ovl_q;

endmodule

>>> src/page_line_pointer_checker_core.sv
// Top level of the slot directory checker: ports, bound registers, counters,
// output register. Depends on plpc_pkg, plpc_ram, plpc_seq and the defines header.
//
// Usage. Input words arrive on in_valid_i / in_stall_o; a word is taken at a
// clock edge where valid is high and stall is low. A load word (operation 0)
// writes one slot entry into the slot table in that cycle and gives no result.
// A check word (operation 1) validates a stored entry and yields one result
// word on out_valid_o / out_stall_i. Words whose slot index is 0 or above the
// table size are dropped without a result.
// Steps. A check reads its entry and then, for a redirect that passes the range
// test, the target entry, or, for an entry that needs the overlap scan, the
// earlier entries one per cycle through the table's single read port, before
// its result is ready. One check is in flight at a time, and in_stall_o stays
// high while it runs.
// The result sits in an output register, so the next word is accepted while a
// result waits; a finished check waits in its last step if the output register
// is still held by a stalled receiver.
// Reset clears the counters, output valid flag and sequencer and sets the bound
// registers to 24, 8192 and 8192; the slot table is not cleared. The user must
// write the bound registers on the cfg channel only while idle; it is unenforced.
`include "page_line_pointer_checker_core_defines.svh"

module page_line_pointer_checker_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [plpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plpc_pkg::POS_W-1:0]      cfg_data_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [plpc_pkg::IDX_W-1:0]      slot_index_i,
  input  logic [1:0]                      slot_flags_i,
  input  logic [plpc_pkg::POS_W-1:0]      slot_offset_i,
  input  logic [plpc_pkg::POS_W-1:0]      slot_length_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [plpc_pkg::IDX_W-1:0]      checked_index_o,
  output logic [2:0]                      verdict_o,
  output logic [plpc_pkg::IDX_W-1:0]      overlap_slot_o,
  output logic [plpc_pkg::CNT_W-1:0]      items_checked_o,
  output logic [plpc_pkg::CNT_W-1:0]      items_failed_o
);
  import plpc_pkg::*;

  // Bound registers, written only from the configuration channel.
  plpc_bounds_t bounds_q, bounds_d;

  // Statistics counters and the output register.
  logic [CNT_W-1:0] checked_q, checked_d;
  logic [CNT_W-1:0] failed_q, failed_d;
  logic             out_valid_q, out_valid_d;
  plpc_result_t     out_res_q;
  logic [CNT_W-1:0] out_checked_q, out_failed_q;

  // Handshake and decode of the incoming word.
  logic        in_fire, idx_ok, ram_we, chk_start, res_ack;
  plpc_entry_t wr_entry, rd_entry;
  logic [SLOT_AW-1:0] raddr;
  logic [IDX_W-1:0]   idx_m1;
  plpc_stat_t   stat;
  plpc_result_t res;

  assign cfg_ready_o = 1'b1;

  // Only one item is handled at a time: the port is stalled while a check runs.
  assign in_stall_o = !stat.idle;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign idx_ok     = (slot_index_i != '0) && (slot_index_i <= MAX_IDX);
  assign ram_we     = in_fire && idx_ok && (operation_i == OP_LOAD);
  assign chk_start  = in_fire && idx_ok && (operation_i == OP_CHECK);
  assign idx_m1     = slot_index_i - IDX_W'(1);

  assign wr_entry.flags = flags_e'(slot_flags_i);
  assign wr_entry.off   = slot_offset_i;
  assign wr_entry.len   = slot_length_i;

  plpc_ram #(
    .Width ($bits(plpc_entry_t)),
    .Depth (MAX_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_m1[SLOT_AW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  plpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (chk_start),
    .start_idx_i (slot_index_i),
    .bounds_i    (bounds_q),
    .rdata_i     (rd_entry),
    .raddr_o     (raddr),
    .res_ack_i   (res_ack),
    .stat_o      (stat),
    .res_o       (res)
  );

  // A finished verdict moves into the output register when that is free or
  // being emptied in the same cycle.
  assign res_ack = stat.res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    bounds_d = bounds_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOWER:   bounds_d.lower   = cfg_data_i;
        CFG_UPPER:   bounds_d.upper   = cfg_data_i;
        CFG_SPECIAL: bounds_d.special = cfg_data_i;
        default:     bounds_d = bounds_q;
      endcase
    end
  end

  // Both counters saturate at all ones.
  always_comb begin
    checked_d   = checked_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_ack) begin
      out_valid_d = 1'b1;
      if (checked_q != '1) begin
        checked_d = checked_q + CNT_W'(1);
      end
      if ((res.verdict != V_OK) && (failed_q != '1)) begin
        failed_d = failed_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.lower   <= LOWER_RST;
      bounds_q.upper   <= UPPER_RST;
      bounds_q.special <= SPECIAL_RST;
      checked_q        <= '0;
      failed_q         <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      bounds_q    <= bounds_d;
      checked_q   <= checked_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_res_q     <= res;
      out_checked_q <= checked_d;
      out_failed_q  <= failed_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign checked_index_o = out_res_q.idx;
  assign verdict_o       = out_res_q.verdict;
  assign overlap_slot_o  = out_res_q.ovl;
  assign items_checked_o = out_checked_q;
  assign items_failed_o  = out_failed_q;

  // An overlap verdict always names a slot, and no other verdict does.
  `PLPC_ASSERT(a_ovl_code, clk_i, rst_ni, out_valid_o |-> ((verdict_o == V_OVERLAP) == (overlap_slot_o != '0)), "overlap slot does not match verdict")
  // The overlapping slot lies before the checked one.
  `PLPC_ASSERT(a_ovl_earlier, clk_i, rst_ni, (out_valid_o && (verdict_o == V_OVERLAP)) |-> (overlap_slot_o < checked_index_o), "overlap slot not earlier")
  // Failures never outnumber checks.
  `PLPC_ASSERT(a_cnt_order, clk_i, rst_ni, out_valid_o |-> (items_failed_o <= items_checked_o), "failed count above checked count")
  // The table is never written while a check reads it.
  `PLPC_ASSERT_ALWAYS(a_no_wr_busy, clk_i, ram_we |-> stat.idle, "table written during a check")

endmodule

>>> dv/page_line_pointer_checker_core_checker.sv
// Checker for the slot directory checker: watches the cfg, input and result channels,
// predicts each verdict word and compares it field by field. Depends on plpc_pkg.
`timescale 1ns / 100ps

module page_line_pointer_checker_core_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [plpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [plpc_pkg::POS_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           operation_i,
  input  logic [plpc_pkg::IDX_W-1:0]     slot_index_i,
  input  logic [1:0]                     slot_flags_i,
  input  logic [plpc_pkg::POS_W-1:0]     slot_offset_i,
  input  logic [plpc_pkg::POS_W-1:0]     slot_length_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [plpc_pkg::IDX_W-1:0]     checked_index_i,
  input  logic [2:0]                     verdict_i,
  input  logic [plpc_pkg::IDX_W-1:0]     overlap_slot_i,
  input  logic [plpc_pkg::CNT_W-1:0]     items_checked_i,
  input  logic [plpc_pkg::CNT_W-1:0]     items_failed_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_o,
  output logic [7:0]                     verdict_seen_o
);
  import plpc_pkg::*;

  localparam int unsigned SLOT_WORD_BYTES = 4;
  localparam logic [CNT_W-1:0] CNT_SAT    = '1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    verdict_e         verdict;
    logic [IDX_W-1:0] ovl;
    logic [CNT_W-1:0] n_checked;
    logic [CNT_W-1:0] n_failed;
  } verdict_word_t;

  plpc_entry_t      slot_tab [MAX_SLOTS];
  plpc_bounds_t     bounds;
  logic [CNT_W-1:0] checked_cnt;
  logic [CNT_W-1:0] failed_cnt;
  verdict_word_t    verdict_q [$];

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    fail_count_o++;
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Validates one stored entry against the bounds, its redirect target or all earlier entries.
  function automatic verdict_e judge_slot(input int unsigned idx, output int unsigned ovl);
    plpc_entry_t ent;
    plpc_entry_t other;
    int unsigned lim;
    int unsigned a_end;
    int unsigned b_end;
    ent = slot_tab[idx-1];
    ovl = 0;
    if (ent.flags == FL_REDIRECT) begin
      if (ent.len != 0) return V_REDIR_LEN;
      lim = (bounds.lower >= HEADER_BYTES) ?
            (bounds.lower - HEADER_BYTES) / SLOT_WORD_BYTES : 0;
      if (ent.off == 0 || ent.off > lim || ent.off > MAX_SLOTS) return V_REDIR_RANGE;
      other = slot_tab[ent.off-1];
      return (other.flags == FL_NORMAL || other.flags == FL_DEAD) ? V_OK : V_REDIR_FLAGS;
    end
    if (ent.flags == FL_UNUSED) return (ent.len != 0) ? V_UNUSED_LEN : V_OK;
    if (ent.flags == FL_DEAD && ent.len == 0) return V_OK;
    if (ent.off < bounds.upper) return V_BELOW_UPPER;
    a_end = ent.off + ent.len;
    if (a_end > bounds.special) return V_PAST_SPEC;
    for (int unsigned k = 1; k < idx; k++) begin
      other = slot_tab[k-1];
      if (other.flags == FL_NORMAL || (other.flags == FL_DEAD && other.len != 0)) begin
        b_end = other.off + other.len;
        if (!(a_end <= other.off || b_end <= ent.off)) begin
          ovl = k;
          return V_OVERLAP;
        end
      end
    end
    return V_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_word_t want;
    verdict_e      v;
    int unsigned   ovl;
    if (!rst_ni) begin
      bounds         = '{lower: LOWER_RST, upper: UPPER_RST, special: SPECIAL_RST};
      checked_cnt    = '0;
      failed_cnt     = '0;
      verdict_seen_o = '0;
      verdict_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LOWER:   bounds.lower   = cfg_data_i;
          CFG_UPPER:   bounds.upper   = cfg_data_i;
          CFG_SPECIAL: bounds.special = cfg_data_i;
          default: ;
        endcase
      end
      // The result taken at this edge belongs to an earlier check, so compare first.
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        verdict_seen_o[verdict_i] = 1'b1;
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with no check outstanding", 0, checked_index_i);
        end else begin
          want = verdict_q.pop_front();
          if (checked_index_i !== want.idx)
            report_mismatch("checked_index", want.idx, checked_index_i);
          if (verdict_i !== want.verdict)
            report_mismatch("verdict", want.verdict, verdict_i);
          if (overlap_slot_i !== want.ovl)
            report_mismatch("overlap_slot", want.ovl, overlap_slot_i);
          if (items_checked_i !== want.n_checked)
            report_mismatch("items_checked", want.n_checked, items_checked_i);
          if (items_failed_i !== want.n_failed)
            report_mismatch("items_failed", want.n_failed, items_failed_i);
        end
      end
      if (in_valid_i && !in_stall_i && slot_index_i != 0 && slot_index_i <= MAX_IDX) begin
        if (operation_i == OP_LOAD) begin
          slot_tab[slot_index_i-1] = '{flags: flags_e'(slot_flags_i),
                                       off:   slot_offset_i,
                                       len:   slot_length_i};
        end else begin
          v = judge_slot(slot_index_i, ovl);
          if (checked_cnt != CNT_SAT) checked_cnt++;
          if (v != V_OK && failed_cnt != CNT_SAT) failed_cnt++;
          verdict_q.push_back('{idx: slot_index_i, verdict: v, ovl: IDX_W'(ovl),
                                n_checked: checked_cnt, n_failed: failed_cnt});
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

>>> dv/page_line_pointer_checker_core_tb.sv
// Testbench top for page_line_pointer_checker_core: clock, reset, stimulus and verdict.
// Depends on plpc_pkg, the block, and page_line_pointer_checker_core_checker.
`timescale 1ns / 100ps

module page_line_pointer_checker_core_tb;
  import plpc_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 126;
  localparam int POS_MAX      = 32767;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = CFG_IDX_W'(3);

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [POS_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 operation   = 1'b0;
  logic [IDX_W-1:0]     slot_index  = '0;
  logic [1:0]           slot_flags  = '0;
  logic [POS_W-1:0]     slot_offset = '0;
  logic [POS_W-1:0]     slot_length = '0;
  logic                 out_stall   = 1'b0;

  logic                 cfg_ready;
  logic                 in_stall;
  logic                 out_valid;
  logic [IDX_W-1:0]     checked_index;
  logic [2:0]           verdict;
  logic [IDX_W-1:0]     overlap_slot;
  logic [CNT_W-1:0]     items_checked;
  logic [CNT_W-1:0]     items_failed;

  int                   fail_count;
  int                   pending;
  int                   results;
  logic [7:0]           verdict_seen;

  // Stimulus bookkeeping. The slot table is not cleared by reset, so a check may
  // only be sent when every entry the block will read has been loaded: the slot
  // itself, every earlier slot if the entry can reach the overlap scan, and the
  // target of a redirect that passes the range test.
  bit                   written [1:MAX_SLOTS];
  bit                   scans   [1:MAX_SLOTS];
  int                   prefix;
  int                   cur_upper;
  int                   fill_pos;
  int                   n_items, n_loads, n_checks, n_dropped;
  int                   cycle_cnt;

  // Receiver control: calm turns off all random idling, hold_arm asks the
  // receiver for one long hold-off, which it counts down on its own.
  bit                   calm;
  bit                   hold_arm;
  bit                   hold_taken;
  int                   hold_left;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  page_line_pointer_checker_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .slot_index_i    (slot_index),
    .slot_flags_i    (slot_flags),
    .slot_offset_i   (slot_offset),
    .slot_length_i   (slot_length),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .checked_index_o (checked_index),
    .verdict_o       (verdict),
    .overlap_slot_o  (overlap_slot),
    .items_checked_o (items_checked),
    .items_failed_o  (items_failed)
  );

  page_line_pointer_checker_core_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .slot_index_i    (slot_index),
    .slot_flags_i    (slot_flags),
    .slot_offset_i   (slot_offset),
    .slot_length_i   (slot_length),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .checked_index_i (checked_index),
    .verdict_i       (verdict),
    .overlap_slot_i  (overlap_slot),
    .items_checked_i (items_checked),
    .items_failed_i  (items_failed),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results),
    .verdict_seen_o  (verdict_seen)
  );

  // Result side. The hold-off outranks the random stalls; while it runs the
  // sender keeps offering words, so the output register and then the check in
  // flight back up until in_stall_o rises.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  // Watchdog. The limit covers every check scanning the full table, with
  // sender gaps, receiver stalls and the hold-off, several times over.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("page_line_pointer_checker_core_tb NOT OK");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high into the next word unless a random gap is drawn, so back-to-back
  // words never lower and raise valid in the same time step.
  task automatic send_word(input op_e op, input logic [IDX_W-1:0] idx, input flags_e fl,
                           input logic [POS_W-1:0] off, input logic [POS_W-1:0] len);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    slot_index  <= idx;
    slot_flags  <= fl;
    slot_offset <= off;
    slot_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_slot(input int idx, input flags_e fl, input int off, input int len);
    send_word(OP_LOAD, IDX_W'(idx), fl, POS_W'(off), POS_W'(len));
    written[idx] = 1'b1;
    scans[idx]   = (fl == FL_NORMAL) || (fl == FL_DEAD && len != 0);
    while (prefix < MAX_SLOTS && written[prefix+1]) prefix++;
    n_items++;
    n_loads++;
  endtask

  // The data fields of a check are ignored by the block; they carry noise.
  task automatic check_slot(input int idx);
    send_word(OP_CHECK, IDX_W'(idx), flags_e'($urandom_range(3)), POS_W'($urandom),
              POS_W'($urandom));
    n_items++;
    n_checks++;
  endtask

  // Words with slot index 0 or past the table are dropped by the block.
  task automatic send_dropped();
    int idx;
    idx = $urandom_range(1) ? 0 : $urandom_range(MAX_SLOTS + 1, 2**IDX_W - 1);
    send_word(op_e'($urandom_range(1)), IDX_W'(idx), flags_e'($urandom_range(3)),
              POS_W'($urandom), POS_W'($urandom));
    n_dropped++;
  endtask

  // Waits until every verdict has come back and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= POS_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_bounds(input int lower, input int upper, input int special);
    write_reg(CFG_LOWER, lower);
    write_reg(CFG_UPPER, upper);
    write_reg(CFG_SPECIAL, special);
    cur_upper = upper;
    fill_pos  = upper;
  endtask

  // Redirect targets are 0, past the table, or a slot that is already loaded,
  // so a target that passes the range test never reads an unloaded entry.
  function automatic int redirect_target();
    int r;
    r = $urandom_range(99);
    if (r < 10 || prefix == 0) return 0;
    if (r < 25) return $urandom_range(MAX_SLOTS + 1, POS_MAX);
    return $urandom_range(1, prefix);
  endfunction

  task automatic load_random();
    int     idx;
    int     off;
    int     len;
    int     r;
    flags_e fl;
    idx = (prefix < MAX_SLOTS && $urandom_range(99) < 65) ? prefix + 1
                                                          : $urandom_range(1, MAX_SLOTS);
    fl  = flags_e'($urandom_range(3));
    if (fl == FL_REDIRECT) begin
      off = redirect_target();
      len = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, POS_MAX);
    end else if (fl == FL_UNUSED) begin
      off = $urandom_range(POS_MAX);
      len = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, POS_MAX);
    end else begin
      r   = $urandom_range(99);
      len = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 64) : $urandom_range(POS_MAX);
      r   = $urandom_range(99);
      if (r < 45) begin
        // Pack entries end to end from the upper bound so that many pass.
        off      = fill_pos;
        fill_pos = fill_pos + len;
        if (fill_pos > POS_MAX) fill_pos = cur_upper;
      end else if (r < 75) begin
        off = cur_upper + $urandom_range(4000);
      end else begin
        off = $urandom_range(POS_MAX);
      end
      if (off > POS_MAX) off = POS_MAX;
    end
    load_slot(idx, fl, off, len);
  endtask

  // Picks a slot whose check reads only loaded entries; falls back to a load.
  task automatic check_random();
    int idx;
    for (int tries = 0; tries < 8; tries++) begin
      idx = (prefix > 0 && $urandom_range(3) != 0) ? $urandom_range(1, prefix)
                                                   : $urandom_range(1, MAX_SLOTS);
      if (written[idx] && (!scans[idx] || prefix >= idx - 1)) begin
        check_slot(idx);
        return;
      end
    end
    load_random();
  endtask

  initial begin
    int goal;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the redirect limit is the whole table and storage starts
    // at 1024, so each verdict code can be reached by hand.
    apply_bounds(HEADER_BYTES + 4 * MAX_SLOTS, 1024, 8192);
    load_slot(1, FL_NORMAL, 1024, 100);        // plain entry in bounds
    check_slot(1);
    load_slot(2, FL_NORMAL, 1050, 10);         // overlaps slot 1
    check_slot(2);
    load_slot(3, FL_REDIRECT, 1, 0);           // redirect to a normal entry
    check_slot(3);
    load_slot(4, FL_REDIRECT, 3, 0);           // redirect to a redirect
    check_slot(4);
    load_slot(5, FL_REDIRECT, 0, 0);           // target 0 is out of range
    check_slot(5);
    load_slot(6, FL_REDIRECT, 2, POS_MAX);     // redirect with storage
    check_slot(6);
    load_slot(7, FL_UNUSED, POS_MAX, 1);       // unused entry with storage
    check_slot(7);
    load_slot(8, FL_NORMAL, 2000, 0);          // zero length, still scanned
    check_slot(8);
    load_slot(9, FL_NORMAL, 100, 50);          // starts below the upper bound
    check_slot(9);
    load_slot(10, FL_NORMAL, 8000, 500);       // runs past the special bound
    check_slot(10);
    load_slot(MAX_SLOTS, FL_DEAD, 0, 0);       // dead without storage, last slot
    check_slot(MAX_SLOTS);
    send_word(OP_CHECK, '0, FL_UNUSED, '0, '0);
    send_word(OP_LOAD, '1, FL_DEAD, '1, '1);
    n_dropped += 2;

    // Random part in five bound settings, extremes among them.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          apply_bounds(HEADER_BYTES + 4 * 100, 4096, 16384);
          write_reg(CFG_NONE, $urandom_range(POS_MAX));
          hold_arm <= 1'b1;
        end
        1: apply_bounds(0, 0, 0);
        2: apply_bounds(POS_MAX, POS_MAX, POS_MAX);
        3: begin
          apply_bounds(HEADER_BYTES - 1, 512, POS_MAX);
          calm <= 1'b1;
        end
        default: begin
          cur_upper = $urandom_range(8192);
          apply_bounds($urandom_range(2200), cur_upper,
                       cur_upper + $urandom_range(POS_MAX - cur_upper));
          calm <= 1'b0;
        end
      endcase
      goal = n_items + PHASE_ITEMS;
      while (n_items < goal) begin
        case ($urandom_range(19))
          0:             send_dropped();
          1, 2, 3, 4, 5,
          6, 7, 8, 9:    load_random();
          default:       check_random();
        endcase
      end
    end

    drain();
    $display("Covered %0d loads and %0d checks (%0d dropped words), %0d verdicts back.",
             n_loads, n_checks, n_dropped, results);
    $display("Verdict codes seen %b; slots 1..%0d loaded in one run.", verdict_seen, prefix);
    if (fail_count == 0) begin
      $display("page_line_pointer_checker_core_tb OK");
    end else begin
      $display("page_line_pointer_checker_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/plpc_pkg.sv
src/plpc_ram.sv
src/plpc_seq.sv
src/page_line_pointer_checker_core.sv
dv/page_line_pointer_checker_core_checker.sv
dv/page_line_pointer_checker_core_tb.sv
